/* rtl/zse_pkg.sv */
// Shared types and constants for the Z80 subset executor.
package zse_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_ED,
    S_IMM_LO,
    S_IMM_HI,
    S_IMM8,
    S_POP_LO,
    S_POP_HI,
    S_HLRD,
    S_PUSH_HI,
    S_CALL,
    S_BLK
  } zse_state_e;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_EXAF = 8'h08;
  localparam logic [7:0] OP_HALT = 8'h76;
  localparam logic [7:0] OP_JP   = 8'hC3;
  localparam logic [7:0] OP_RET  = 8'hC9;
  localparam logic [7:0] OP_CALL = 8'hCD;
  localparam logic [7:0] OP_OUT  = 8'hD3;
  localparam logic [7:0] OP_EXX  = 8'hD9;
  localparam logic [7:0] OP_ED   = 8'hED;
  localparam logic [7:0] OP_DI   = 8'hF3;
  localparam logic [7:0] OP_EI   = 8'hFB;

  localparam logic [7:0] ED_IM0A = 8'h46;
  localparam logic [7:0] ED_IM0B = 8'h66;
  localparam logic [7:0] ED_IM1A = 8'h56;
  localparam logic [7:0] ED_IM1B = 8'h76;
  localparam logic [7:0] ED_IM2A = 8'h5E;
  localparam logic [7:0] ED_IM2B = 8'h7E;
  localparam logic [7:0] ED_LDI  = 8'hA0;
  localparam logic [7:0] ED_LDD  = 8'hA8;
  localparam logic [7:0] ED_LDIR = 8'hB0;
  localparam logic [7:0] ED_LDDR = 8'hB8;

  localparam logic [6:0] CYC_UNKNOWN = 7'd69;
  localparam logic [15:0] SP_RESET   = 16'hFFFF;

endpackage

/* rtl/zse_ram.sv */
// Single-port byte memory with registered read data.
module zse_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [7:0]           wdata_i,
  output logic [7:0]           rdata_o
);

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/z80_subset_instruction_executor.sv */
// Top level: sequencer and register file of the Z80 subset executor.
// An item with func_i low writes one memory byte and reports in the next cycle; an item with
// func_i high runs one instruction, stepping through one state per access of the single memory
// port. The result appears on done_o for one cycle and cannot be held off. After reset a
// clearing pass writes zero to all 2**ADDR_BITS bytes, one per cycle, with busy high throughout.
module z80_subset_instruction_executor #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  output logic        done_o,
  output logic [6:0]  cycles_o,
  output logic [15:0] pc_o,
  output logic        port_valid_o,
  output logic [7:0]  port_number_o,
  output logic [7:0]  port_value_o
);
  import zse_pkg::*;

  zse_state_e state_q, state_d;
  logic [15:0] af_q, bc_q, de_q, hl_q, af2_q, bc2_q, de2_q, hl2_q;
  logic [15:0] af_d, bc_d, de_d, hl_d, af2_d, bc2_d, de2_d, hl2_d;
  logic [15:0] sp_q, sp_d, pc_q, pc_d;
  logic [7:0]  r_q, r_d, op_q, op_d, tmp_q, tmp_d;
  logic [1:0]  iff_q, iff_d, im_q, im_d;
  logic [ADDR_BITS-1:0] clr_q, clr_d;
  logic        done_q, pv_q, pv_d;
  logic [6:0]  cyc_q, cyc_d;
  logic [15:0] pco_q;
  logic [7:0]  pn_q, pn_d, pval_q, pval_d;
  logic        fin;

  logic        mem_we;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wdata, mem_rdata;

  zse_ram #(.ADDR_BITS(ADDR_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  ((state_q == S_CLEAR) ? clr_q : mem_addr[ADDR_BITS-1:0]),
    .wdata_i ((state_q == S_CLEAR) ? 8'h00 : mem_wdata),
    .rdata_o (mem_rdata)
  );

  function automatic logic [7:0] get_r8(input logic [2:0] idx, input logic [15:0] af,
                                        input logic [15:0] bc, input logic [15:0] de,
                                        input logic [15:0] hl);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = bc[15:8];
      3'd1: v = bc[7:0];
      3'd2: v = de[15:8];
      3'd3: v = de[7:0];
      3'd4: v = hl[15:8];
      3'd5: v = hl[7:0];
      3'd7: v = af[15:8];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Condition code test against the current flags.
  function automatic logic cond_ok(input logic [2:0] cc, input logic [7:0] f);
    logic s;
    unique case (cc[2:1])
      2'd0: s = f[6];
      2'd1: s = f[0];
      2'd2: s = f[2];
      default: s = f[7];
    endcase
    return cc[0] ? s : ~s;
  endfunction

  logic [7:0]  opc;
  logic        opc_ld;
  logic [15:0] word;
  logic [15:0] bc_dec;
  logic        cond_q;

  assign opc    = mem_rdata;
  assign opc_ld = (opc[7:6] == 2'b01) && (opc != OP_HALT);
  assign word   = {mem_rdata, tmp_q};
  assign bc_dec = bc_q - 16'd1;
  assign cond_q = cond_ok(op_q[5:3], af_q[7:0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (&clr_q) state_d = S_IDLE;
      S_IDLE: begin
        if (start && func_i) state_d = S_OP;
      end
      S_OP: begin
        state_d = S_IDLE;
        if (opc_ld) begin
          if (opc[2:0] == 3'd6) state_d = S_HLRD;
        end else if (opc[7:6] == 2'b00) begin
          if (opc[3:0] == 4'h1) state_d = S_IMM_LO;
          else if (opc[2:0] == 3'd6) state_d = S_IMM8;
        end else if (opc[7:6] == 2'b11) begin
          if (opc[2:0] == 3'd0) begin
            if (cond_ok(opc[5:3], af_q[7:0])) state_d = S_POP_LO;
          end else if (opc[2:0] == 3'd2 || opc == OP_JP) begin
            state_d = S_IMM_LO;
          end else if (opc[3:0] == 4'h1 || opc == OP_RET) begin
            state_d = S_POP_LO;
          end else if (opc[3:0] == 4'h5 || opc == OP_CALL) begin
            state_d = S_PUSH_HI;
          end else if (opc == OP_OUT) begin
            state_d = S_IMM8;
          end else if (opc == OP_ED) begin
            state_d = S_ED;
          end
        end
      end
      S_ED: begin
        if (opc == ED_LDI || opc == ED_LDD || opc == ED_LDIR || opc == ED_LDDR) begin
          state_d = S_BLK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IMM_LO:  state_d = S_IMM_HI;
      S_POP_LO:  state_d = S_POP_HI;
      S_PUSH_HI: state_d = (op_q == OP_CALL) ? S_CALL : S_IDLE;
      S_CALL:    state_d = S_IMM_LO;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    af_d = af_q; bc_d = bc_q; de_d = de_q; hl_d = hl_q;
    af2_d = af2_q; bc2_d = bc2_q; de2_d = de2_q; hl2_d = hl2_q;
    sp_d = sp_q; pc_d = pc_q; r_d = r_q; op_d = op_q; tmp_d = tmp_q;
    iff_d = iff_q; im_d = im_q;
    clr_d = clr_q;
    mem_we = 1'b0; mem_addr = pc_q; mem_wdata = 8'h00;
    fin = 1'b0; cyc_d = cyc_q; pv_d = 1'b0; pn_d = 8'h00; pval_d = 8'h00;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          if (!func_i) begin
            mem_we = 1'b1; mem_addr = addr_i; mem_wdata = data_i;
            fin = 1'b1; cyc_d = 7'd0;
          end else begin
            r_d  = {r_q[7], r_q[6:0] + 7'd1};
            pc_d = pc_q + 16'd1;
          end
        end
      end
      S_OP: begin
        op_d = opc;
        if (opc_ld) begin
          if (opc[2:0] == 3'd6) begin
            mem_addr = hl_q;
          end else if (opc[5:3] == 3'd6) begin
            mem_we = 1'b1; mem_addr = hl_q;
            mem_wdata = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
            fin = 1'b1; cyc_d = 7'd7;
          end else begin
            unique case (opc[5:3])
              3'd0: bc_d[15:8] = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
              3'd1: bc_d[7:0]  = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
              3'd2: de_d[15:8] = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
              3'd3: de_d[7:0]  = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
              3'd4: hl_d[15:8] = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
              3'd5: hl_d[7:0]  = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
              default: af_d[15:8] = get_r8(opc[2:0], af_q, bc_q, de_q, hl_q);
            endcase
            fin = 1'b1; cyc_d = 7'd4;
          end
        end else if (opc[7:6] == 2'b00) begin
          if (opc[3:0] == 4'h1 || opc[2:0] == 3'd6) begin
            pc_d = pc_q + 16'd1;
          end else if (opc[3:0] == 4'h3 || opc[3:0] == 4'hB) begin
            unique case (opc[5:4])
              2'd0: bc_d = opc[3] ? bc_q - 16'd1 : bc_q + 16'd1;
              2'd1: de_d = opc[3] ? de_q - 16'd1 : de_q + 16'd1;
              2'd2: hl_d = opc[3] ? hl_q - 16'd1 : hl_q + 16'd1;
              default: sp_d = opc[3] ? sp_q - 16'd1 : sp_q + 16'd1;
            endcase
            fin = 1'b1; cyc_d = 7'd6;
          end else if (opc == OP_NOP) begin
            fin = 1'b1; cyc_d = 7'd4;
          end else if (opc == OP_EXAF) begin
            af_d = af2_q; af2_d = af_q;
            fin = 1'b1; cyc_d = 7'd4;
          end else begin
            fin = 1'b1; cyc_d = CYC_UNKNOWN;
          end
        end else if (opc[7:6] == 2'b11) begin
          if (opc[2:0] == 3'd0) begin
            mem_addr = sp_q;
            if (!cond_ok(opc[5:3], af_q[7:0])) begin
              fin = 1'b1; cyc_d = 7'd5;
            end
          end else if (opc[2:0] == 3'd2 || opc == OP_JP || opc == OP_OUT
                       || opc == OP_ED) begin
            pc_d = pc_q + 16'd1;
            if (opc == OP_ED) r_d = {r_q[7], r_q[6:0] + 7'd1};
          end else if (opc[3:0] == 4'h1 || opc == OP_RET) begin
            mem_addr = sp_q;
          end else if (opc[3:0] == 4'h5 || opc == OP_CALL) begin
            // The low byte goes out now; the high byte waits in tmp_q.
            logic [15:0] pw;
            if (opc == OP_CALL) begin
              pw = pc_q + 16'd2;
            end else begin
              unique case (opc[5:4])
                2'd0: pw = bc_q;
                2'd1: pw = de_q;
                2'd2: pw = hl_q;
                default: pw = af_q;
              endcase
            end
            sp_d = sp_q - 16'd2;
            mem_we = 1'b1; mem_addr = sp_q - 16'd2; mem_wdata = pw[7:0];
            tmp_d = pw[15:8];
          end else if (opc == OP_EXX) begin
            bc_d = bc2_q; bc2_d = bc_q; de_d = de2_q; de2_d = de_q;
            hl_d = hl2_q; hl2_d = hl_q;
            fin = 1'b1; cyc_d = 7'd4;
          end else if (opc == OP_DI || opc == OP_EI) begin
            iff_d = (opc == OP_EI) ? 2'b11 : 2'b00;
            fin = 1'b1; cyc_d = 7'd4;
          end else begin
            fin = 1'b1; cyc_d = CYC_UNKNOWN;
          end
        end else begin
          fin = 1'b1; cyc_d = CYC_UNKNOWN;
        end
      end
      S_ED: begin
        op_d = opc;
        fin = 1'b1; cyc_d = 7'd8;
        if (opc == ED_IM0A || opc == ED_IM0B) begin
          im_d = 2'd0;
        end else if (opc == ED_IM1A || opc == ED_IM1B) begin
          im_d = 2'd1;
        end else if (opc == ED_IM2A || opc == ED_IM2B) begin
          im_d = 2'd2;
        end else if (opc == ED_LDI || opc == ED_LDD || opc == ED_LDIR || opc == ED_LDDR) begin
          mem_addr = hl_q; fin = 1'b0;
        end else begin
          cyc_d = CYC_UNKNOWN;
        end
      end
      S_IMM_LO: begin
        tmp_d = mem_rdata;
        pc_d  = pc_q + 16'd1;
      end
      S_IMM_HI: begin
        fin = 1'b1; cyc_d = 7'd10;
        if (op_q[7:6] == 2'b00) begin
          unique case (op_q[5:4])
            2'd0: bc_d = word;
            2'd1: de_d = word;
            2'd2: hl_d = word;
            default: sp_d = word;
          endcase
        end else if (op_q == OP_CALL) begin
          pc_d = word; cyc_d = 7'd17;
        end else if (op_q == OP_JP || cond_q) begin
          pc_d = word;
        end
      end
      S_POP_LO: begin
        tmp_d = mem_rdata;
        mem_addr = sp_q + 16'd1;
      end
      S_POP_HI: begin
        sp_d = sp_q + 16'd2;
        fin = 1'b1; cyc_d = 7'd10;
        if (op_q[3:0] == 4'h1) begin
          unique case (op_q[5:4])
            2'd0: bc_d = word;
            2'd1: de_d = word;
            2'd2: hl_d = word;
            default: af_d = word;
          endcase
        end else begin
          pc_d = word;
          if (op_q != OP_RET) cyc_d = 7'd11;
        end
      end
      S_IMM8: begin
        fin = 1'b1;
        if (op_q == OP_OUT) begin
          cyc_d = 7'd11; pv_d = 1'b1; pn_d = mem_rdata; pval_d = af_q[15:8];
        end else begin
          cyc_d = 7'd7;
          unique case (op_q[5:3])
            3'd0: bc_d[15:8] = mem_rdata;
            3'd1: bc_d[7:0]  = mem_rdata;
            3'd2: de_d[15:8] = mem_rdata;
            3'd3: de_d[7:0]  = mem_rdata;
            3'd4: hl_d[15:8] = mem_rdata;
            3'd5: hl_d[7:0]  = mem_rdata;
            3'd6: begin
              mem_we = 1'b1; mem_addr = hl_q; mem_wdata = mem_rdata; cyc_d = 7'd10;
            end
            default: af_d[15:8] = mem_rdata;
          endcase
        end
      end
      S_HLRD: begin
        fin = 1'b1; cyc_d = 7'd7;
        unique case (op_q[5:3])
          3'd0: bc_d[15:8] = mem_rdata;
          3'd1: bc_d[7:0]  = mem_rdata;
          3'd2: de_d[15:8] = mem_rdata;
          3'd3: de_d[7:0]  = mem_rdata;
          3'd4: hl_d[15:8] = mem_rdata;
          3'd5: hl_d[7:0]  = mem_rdata;
          default: af_d[15:8] = mem_rdata;
        endcase
      end
      S_PUSH_HI: begin
        mem_we = 1'b1; mem_addr = sp_q + 16'd1; mem_wdata = tmp_q;
        if (op_q != OP_CALL) begin
          fin = 1'b1; cyc_d = 7'd11;
        end
      end
      S_CALL: begin
        pc_d = pc_q + 16'd1;
      end
      S_BLK: begin
        mem_we = 1'b1; mem_addr = de_q; mem_wdata = mem_rdata;
        de_d = op_q[3] ? de_q - 16'd1 : de_q + 16'd1;
        hl_d = op_q[3] ? hl_q - 16'd1 : hl_q + 16'd1;
        bc_d = bc_dec;
        af_d[2] = (bc_dec != 16'd0);
        af_d[4] = 1'b0;
        af_d[1] = 1'b0;
        fin = 1'b1; cyc_d = 7'd16;
        if (op_q[4] && bc_dec != 16'd0) begin
          pc_d = pc_q - 16'd2; cyc_d = 7'd21;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      af_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0;
      af2_q <= '0; bc2_q <= '0; de2_q <= '0; hl2_q <= '0;
      sp_q <= SP_RESET; pc_q <= '0; r_q <= '0; iff_q <= '0; im_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      af_q <= af_d; bc_q <= bc_d; de_q <= de_d; hl_q <= hl_d;
      af2_q <= af2_d; bc2_q <= bc2_d; de2_q <= de2_d; hl2_q <= hl2_d;
      sp_q <= sp_d; pc_q <= pc_d; r_q <= r_d; iff_q <= iff_d; im_q <= im_d;
      done_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    tmp_q <= tmp_d;
    if (fin) begin
      cyc_q  <= cyc_d;
      pco_q  <= pc_d;
      pv_q   <= pv_d;
      pn_q   <= pn_d;
      pval_q <= pval_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign cycles_o      = cyc_q;
  assign pc_o          = pco_q;
  assign port_valid_o  = pv_q;
  assign port_number_o = pn_q;
  assign port_value_o  = pval_q;

`ifndef SYNTHESIS
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> busy) else $error("clearing pass not busy");
  a_write_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !func_i |=> done_o && cycles_o == 7'd0)
    else $error("memory write item not reported");
  a_port_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && port_valid_o |-> cycles_o == 7'd11) else $error("port write with wrong cost");
  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) != S_CLEAR) else $error("result during clearing pass");
`endif

endmodule

/* tb/sv/z80_subset_instruction_executor_tb.sv */
// Self-checking testbench for the Z80 subset executor: directed and random programs.
`timescale 1ns / 1ps

module z80_subset_instruction_executor_tb;
  import zse_pkg::*;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EXEC  = 1'b1;

  localparam logic [7:0] OP_LD_BC_NN = 8'h01;
  localparam logic [7:0] OP_LD_DE_NN = 8'h11;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_INC_HL   = 8'h23;
  localparam logic [7:0] OP_DEC_BC   = 8'h0B;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_MHL_N = 8'h36;
  localparam logic [7:0] OP_LD_A_MHL = 8'h7E;
  localparam logic [7:0] OP_LD_B_A   = 8'h47;
  localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
  localparam logic [7:0] OP_POP_DE   = 8'hD1;
  localparam logic [7:0] OP_JP_Z     = 8'hCA;
  localparam logic [7:0] OP_RET_NZ   = 8'hC0;
  localparam logic [7:0] OP_BAD      = 8'hDD;
  localparam logic [7:0] ED_BAD      = 8'h00;

  localparam logic [7:0] FLAG_PV = 8'h04;
  localparam logic [7:0] FLAG_HN = 8'h12;

  typedef struct packed {
    logic        func;
    logic [15:0] addr;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cyc;
    logic [15:0] pc;
    logic        pv;
    logic [7:0]  pnum;
    logic [7:0]  pval;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [15:0] addr_i = '0;
  logic [7:0]  data_i = '0;
  logic        done_o;
  logic [6:0]  cycles_o;
  logic [15:0] pc_o;
  logic        port_valid_o;
  logic [7:0]  port_number_o;
  logic [7:0]  port_value_o;

  z80_subset_instruction_executor u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .func_i(func_i), .addr_i(addr_i), .data_i(data_i), .done_o(done_o),
    .cycles_o(cycles_o), .pc_o(pc_o), .port_valid_o(port_valid_o),
    .port_number_o(port_number_o), .port_value_o(port_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow machine state.
  logic [7:0]  cpu_mem [65536];
  logic [15:0] main_rp [4];   // AF, BC, DE, HL
  logic [15:0] alt_rp [4];
  logic [15:0] cpu_sp, cpu_pc;
  logic [1:0]  cpu_iff, cpu_im;

  cmd_t     cmd_q [$];
  outcome_t outcome_q [$];
  cmd_t     cur_cmd;
  int       cmd_cnt = 0, outcome_cnt = 0;
  bit       item_live = 1'b0;
  int       gap_left = 0, burst_left = 8;
  int       mismatches = 0, checked = 0, n_exec = 0, n_port = 0, n_block = 0;

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = cpu_mem[cpu_pc];
    cpu_pc = cpu_pc + 16'd1;
    return b;
  endfunction

  function automatic logic [15:0] fetch_wd();
    logic [7:0] lo;
    lo = fetch_byte();
    return {fetch_byte(), lo};
  endfunction

  function automatic void push_wd(logic [15:0] w);
    cpu_sp = cpu_sp - 16'd2;
    cpu_mem[cpu_sp] = w[7:0];
    cpu_mem[16'(cpu_sp + 16'd1)] = w[15:8];
  endfunction

  function automatic logic [15:0] pop_wd();
    logic [15:0] w;
    w = {cpu_mem[16'(cpu_sp + 16'd1)], cpu_mem[cpu_sp]};
    cpu_sp = cpu_sp + 16'd2;
    return w;
  endfunction

  function automatic logic [7:0] reg8(logic [2:0] r);
    if (r == 3'd6) return cpu_mem[main_rp[3]];
    if (r == 3'd7) return main_rp[0][15:8];
    return r[0] ? main_rp[1 + r[2:1]][7:0] : main_rp[1 + r[2:1]][15:8];
  endfunction

  function automatic void put_reg8(logic [2:0] r, logic [7:0] v);
    if (r == 3'd6) cpu_mem[main_rp[3]] = v;
    else if (r == 3'd7) main_rp[0][15:8] = v;
    else if (r[0]) main_rp[1 + r[2:1]][7:0] = v;
    else main_rp[1 + r[2:1]][15:8] = v;
  endfunction

  function automatic logic [15:0] get_rp(logic [1:0] p);
    return (p == 2'd3) ? cpu_sp : main_rp[1 + p];
  endfunction

  function automatic void put_rp(logic [1:0] p, logic [15:0] v);
    if (p == 2'd3) cpu_sp = v;
    else main_rp[1 + p] = v;
  endfunction

  function automatic bit cond_met(logic [2:0] cc);
    logic [7:0] f;
    bit flag;
    f = main_rp[0][7:0];
    case (cc[2:1])
      2'd0: flag = f[6];
      2'd1: flag = f[0];
      2'd2: flag = f[2];
      default: flag = f[7];
    endcase
    return cc[0] ? flag : !flag;
  endfunction

  function automatic void block_step(bit down);
    logic [7:0] f;
    cpu_mem[main_rp[2]] = cpu_mem[main_rp[3]];
    main_rp[3] = down ? main_rp[3] - 16'd1 : main_rp[3] + 16'd1;
    main_rp[2] = down ? main_rp[2] - 16'd1 : main_rp[2] + 16'd1;
    main_rp[1] = main_rp[1] - 16'd1;
    f = main_rp[0][7:0];
    f = (main_rp[1] != 16'd0) ? (f | FLAG_PV) : (f & ~FLAG_PV);
    main_rp[0][7:0] = f & ~FLAG_HN;
  endfunction

  function automatic logic [6:0] run_ed();
    logic [7:0] op;
    op = fetch_byte();
    case (op)
      ED_IM0A, ED_IM0B: begin cpu_im = 2'd0; return 7'd8; end
      ED_IM1A, ED_IM1B: begin cpu_im = 2'd1; return 7'd8; end
      ED_IM2A, ED_IM2B: begin cpu_im = 2'd2; return 7'd8; end
      ED_LDI: begin block_step(1'b0); n_block++; return 7'd16; end
      ED_LDD: begin block_step(1'b1); n_block++; return 7'd16; end
      ED_LDIR, ED_LDDR: begin
        block_step(op == ED_LDDR);
        n_block++;
        if (main_rp[1] != 16'd0) begin
          cpu_pc = cpu_pc - 16'd2;
          return 7'd21;
        end
        return 7'd16;
      end
      default: return CYC_UNKNOWN;
    endcase
  endfunction

  // Works out the outcome of one item and advances the shadow state.
  function automatic outcome_t execute_item(cmd_t c);
    outcome_t o;
    logic [7:0] op;
    logic [15:0] t;
    o = '0;
    if (c.func == FUNC_WRITE) begin
      cpu_mem[c.addr] = c.data;
      o.pc = cpu_pc;
      return o;
    end
    n_exec++;
    op = fetch_byte();
    if (op >= 8'h40 && op <= 8'h7F && op != OP_HALT) begin
      put_reg8(op[5:3], reg8(op[2:0]));
      o.cyc = (op[5:3] == 3'd6 || op[2:0] == 3'd6) ? 7'd7 : 7'd4;
    end else if (op < 8'h40) begin
      case (op[3:0])
        4'h1: begin put_rp(op[5:4], fetch_wd()); o.cyc = 7'd10; end
        4'h3: begin put_rp(op[5:4], get_rp(op[5:4]) + 16'd1); o.cyc = 7'd6; end
        4'hB: begin put_rp(op[5:4], get_rp(op[5:4]) - 16'd1); o.cyc = 7'd6; end
        4'h6, 4'hE: begin
          put_reg8(op[5:3], fetch_byte());
          o.cyc = (op[5:3] == 3'd6) ? 7'd10 : 7'd7;
        end
        default: begin
          if (op == OP_NOP) o.cyc = 7'd4;
          else if (op == OP_EXAF) begin
            t = main_rp[0]; main_rp[0] = alt_rp[0]; alt_rp[0] = t;
            o.cyc = 7'd4;
          end else o.cyc = CYC_UNKNOWN;
        end
      endcase
    end else if (op >= 8'hC0) begin
      case (op[3:0])
        4'h0, 4'h8: begin
          if (cond_met(op[5:3])) begin cpu_pc = pop_wd(); o.cyc = 7'd11; end
          else o.cyc = 7'd5;
        end
        4'h2, 4'hA: begin
          t = fetch_wd();
          if (cond_met(op[5:3])) cpu_pc = t;
          o.cyc = 7'd10;
        end
        4'h1: begin
          t = pop_wd();
          if (op[5:4] == 2'd3) main_rp[0] = t; else main_rp[1 + op[5:4]] = t;
          o.cyc = 7'd10;
        end
        4'h5: begin
          push_wd((op[5:4] == 2'd3) ? main_rp[0] : main_rp[1 + op[5:4]]);
          o.cyc = 7'd11;
        end
        default: begin
          case (op)
            OP_JP: begin cpu_pc = fetch_wd(); o.cyc = 7'd10; end
            OP_RET: begin cpu_pc = pop_wd(); o.cyc = 7'd10; end
            OP_CALL: begin
              push_wd(cpu_pc + 16'd2);
              cpu_pc = fetch_wd();
              o.cyc = 7'd17;
            end
            OP_OUT: begin
              o.pnum = fetch_byte();
              o.pval = main_rp[0][15:8];
              o.pv = 1'b1;
              n_port++;
              o.cyc = 7'd11;
            end
            OP_EXX: begin
              for (int i = 1; i < 4; i++) begin
                t = main_rp[i]; main_rp[i] = alt_rp[i]; alt_rp[i] = t;
              end
              o.cyc = 7'd4;
            end
            OP_ED: o.cyc = run_ed();
            OP_DI: begin cpu_iff = 2'd0; o.cyc = 7'd4; end
            OP_EI: begin cpu_iff = 2'd3; o.cyc = 7'd4; end
            default: o.cyc = CYC_UNKNOWN;
          endcase
        end
      endcase
    end else begin
      o.cyc = CYC_UNKNOWN;
    end
    o.pc = cpu_pc;
    return o;
  endfunction

  // Checks results, then logs the item accepted at this edge.
  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: pc=%h cycles=%0d", pc_o, cycles_o);
      end else begin
        exp_o = outcome_q.pop_front();
        outcome_cnt--;
        checked++;
        if (cycles_o !== exp_o.cyc || pc_o !== exp_o.pc || port_valid_o !== exp_o.pv ||
            port_number_o !== exp_o.pnum || port_value_o !== exp_o.pval) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cyc=%0d pc=%h pv=%b pn=%h pd=%h, got cyc=%0d pc=%h pv=%b pn=%h pd=%h",
                     exp_o.cyc, exp_o.pc, exp_o.pv, exp_o.pnum, exp_o.pval,
                     cycles_o, pc_o, port_valid_o, port_number_o, port_value_o);
        end
      end
    end
    if (rst_ni && start && !busy && item_live) begin
      outcome_q.push_back(execute_item(cur_cmd));
      outcome_cnt++;
      item_live = 1'b0;
    end
  end

  // Sender: bursts of back-to-back items separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!item_live) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur_cmd = cmd_q.pop_front();
        cmd_cnt--;
        item_live = 1'b1;
        start <= 1'b1;
        func_i <= cur_cmd.func;
        addr_i <= cur_cmd.addr;
        data_i <= cur_cmd.data;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic send(logic f, logic [15:0] a, logic [7:0] d);
    cmd_q.push_back('{func: f, addr: a, data: d});
    cmd_cnt++;
  endtask

  // Places one instruction at the current program counter and runs it.
  task automatic run_instr(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    logic [15:0] p;
    wait (cmd_cnt == 0 && !item_live);
    p = cpu_pc;
    send(FUNC_WRITE, p, b0);
    send(FUNC_WRITE, 16'(p + 16'd1), b1);
    send(FUNC_WRITE, 16'(p + 16'd2), b2);
    send(FUNC_WRITE, 16'(p + 16'd3), b3);
    send(FUNC_EXEC, 16'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [7:0] op, b1;
    int kind;
    foreach (cpu_mem[i]) cpu_mem[i] = 8'h00;
    foreach (main_rp[i]) begin main_rp[i] = '0; alt_rp[i] = '0; end
    cpu_sp = SP_RESET;
    cpu_pc = '0;
    cpu_iff = '0;
    cpu_im = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes and every instruction group.
    send(FUNC_WRITE, 16'hFFFF, 8'hFF);
    send(FUNC_WRITE, 16'h0000, 8'h00);
    run_instr(OP_LD_A_N, 8'hFF, 8'h00, 8'h00);
    run_instr(OP_OUT, 8'hFF, 8'h00, 8'h00);
    run_instr(OP_OUT, 8'h00, 8'h00, 8'h00);
    run_instr(OP_HALT, 8'h00, 8'h00, 8'h00);
    run_instr(OP_BAD, 8'h00, 8'h00, 8'h00);
    run_instr(OP_ED, ED_BAD, 8'h00, 8'h00);
    run_instr(OP_LD_BC_NN, 8'h03, 8'h00, 8'h00);
    run_instr(OP_LD_HL_NN, 8'h00, 8'h10, 8'h00);
    run_instr(OP_LD_DE_NN, 8'h00, 8'h20, 8'h00);
    run_instr(OP_LD_MHL_N, 8'hA5, 8'h00, 8'h00);
    run_instr(OP_LD_A_MHL, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 3; i++) begin
      wait (cmd_cnt == 0 && !item_live);
      if (i == 0) run_instr(OP_ED, ED_LDIR, 8'h00, 8'h00);
      else send(FUNC_EXEC, 16'h0000, 8'h00);
    end
    run_instr(OP_LD_BC_NN, 8'h02, 8'h00, 8'h00);
    run_instr(OP_ED, ED_LDDR, 8'h00, 8'h00);
    send(FUNC_EXEC, 16'h0000, 8'h00);
    run_instr(OP_ED, ED_LDI, 8'h00, 8'h00);
    run_instr(OP_ED, ED_LDD, 8'h00, 8'h00);
    run_instr(OP_ED, ED_IM0A, 8'h00, 8'h00);
    run_instr(OP_ED, ED_IM1B, 8'h00, 8'h00);
    run_instr(OP_ED, ED_IM2A, 8'h00, 8'h00);
    run_instr(OP_DI, 8'h00, 8'h00, 8'h00);
    run_instr(OP_EI, 8'h00, 8'h00, 8'h00);
    run_instr(OP_EXX, 8'h00, 8'h00, 8'h00);
    run_instr(OP_EXAF, 8'h00, 8'h00, 8'h00);
    run_instr(OP_LD_B_A, 8'h00, 8'h00, 8'h00);
    run_instr(OP_LD_SP_NN, 8'h00, 8'h80, 8'h00);
    run_instr(OP_PUSH_BC, 8'h00, 8'h00, 8'h00);
    run_instr(OP_POP_DE, 8'h00, 8'h00, 8'h00);
    run_instr(OP_INC_HL, 8'h00, 8'h00, 8'h00);
    run_instr(OP_DEC_BC, 8'h00, 8'h00, 8'h00);
    run_instr(OP_CALL, 8'h00, 8'h30, 8'h00);
    run_instr(OP_RET_NZ, 8'h00, 8'h00, 8'h00);
    run_instr(OP_JP_Z, 8'h34, 8'h12, 8'h00);
    run_instr(OP_RET, 8'h00, 8'h00, 8'h00);
    run_instr(OP_JP, 8'hFF, 8'hFF, 8'h00);
    run_instr(OP_NOP, 8'h00, 8'h00, 8'h00);

    // Hold off until every outstanding result has come back.
    wait (cmd_cnt == 0 && !item_live);
    wait (outcome_cnt == 0);

    // Random: random opcode bytes and block moves, some raw writes and bare executes.
    for (int g = 0; g < 200; g++) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        send(FUNC_WRITE, 16'($urandom), 8'($urandom));
      end else if (kind < 15) begin
        send(FUNC_EXEC, 16'($urandom), 8'($urandom));
      end else if (kind < 22) begin
        run_instr(OP_LD_BC_NN, 8'($urandom_range(0, 4)), 8'h00, 8'h00);
        b1 = $urandom_range(1) ? ED_LDIR : ED_LDDR;
        run_instr(OP_ED, b1, 8'($urandom), 8'($urandom));
      end else begin
        op = 8'($urandom);
        b1 = 8'($urandom);
        if ($urandom_range(6) == 0) begin
          op = OP_ED;
          case ($urandom_range(4))
            0: b1 = ED_LDI;
            1: b1 = ED_LDD;
            2: b1 = ED_IM2B;
            3: b1 = ED_IM0B;
            default: b1 = 8'($urandom);
          endcase
        end
        run_instr(op, b1, 8'($urandom), 8'($urandom));
      end
    end

    wait (cmd_cnt == 0 && !item_live);
    wait (outcome_cnt == 0);
    repeat (20) @(posedge clk_i);
    $display("Checked %0d results: %0d instructions, %0d port writes, %0d block moves.",
             checked, n_exec, n_port, n_block);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Covers the clearing pass after reset and the whole run with a wide margin.
  initial begin
    #3ms;
    $display("Timed out.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/zse_pkg.sv
rtl/zse_ram.sv
rtl/z80_subset_instruction_executor.sv
tb/sv/z80_subset_instruction_executor_tb.sv
